### rtl/core/dac_pkg.sv
package dac_pkg;

  // Default size of main memory in words
  localparam int unsigned MemoryWordsDefault = 10000;

  // Item widths on the stream ports
  localparam int unsigned InDataW   = 80;
  localparam int unsigned InUserW   = 1;
  localparam int unsigned OutDataW  = 80;
  localparam int unsigned OutUserW  = 4;
  localparam int unsigned AddrFieldW = 14;

  // Item kinds
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_EXECUTED = 3'd2;
  localparam logic [2:0] ST_HALTED   = 3'd3;
  localparam logic [2:0] ST_ILLEGAL  = 3'd4;
  localparam logic [2:0] ST_OFF_END  = 3'd5;
  localparam logic [2:0] ST_DIV_ZERO = 3'd6;
  localparam logic [2:0] ST_RUNNING  = 3'd0;

  // Opcodes
  localparam logic signed [31:0] OP_NOP   = 32'sd0;
  localparam logic signed [31:0] OP_ADD   = 32'sd1;
  localparam logic signed [31:0] OP_SUB   = 32'sd2;
  localparam logic signed [31:0] OP_MUL   = 32'sd3;
  localparam logic signed [31:0] OP_DIV   = 32'sd4;
  localparam logic signed [31:0] OP_LOAD  = 32'sd5;
  localparam logic signed [31:0] OP_STORE = 32'sd6;
  localparam logic signed [31:0] OP_READ  = 32'sd7;
  localparam logic signed [31:0] OP_WRITE = 32'sd8;
  localparam logic signed [31:0] OP_BR    = 32'sd9;
  localparam logic signed [31:0] OP_BRN   = 32'sd10;
  localparam logic signed [31:0] OP_BRZ   = 32'sd11;
  localparam logic signed [31:0] OP_BRP   = 32'sd12;
  localparam logic signed [31:0] OP_HALT  = 32'sd13;

endpackage

### rtl/core/decimal_accumulator_cpu.sv
// Decimal accumulator machine.
// Input channel s_axis: tuser selects the item kind (0 load a program word,
// 1 execute one instruction); tdata carries load_address, load_word and
// read_value. Output channel m_axis: one result item per input item with the
// status and write flag in tuser and write_value, accumulator and
// program_counter in tdata.
// After reset the block clears main memory, one word a cycle, all
// MemoryWords words; s_axis_tready stays low during that pass.
// One item is worked on at a time. A step on a stopped machine or a load
// past the end of memory is answered straight from idle; a load does a cell
// check read, then write; a step does fetch, the reciprocal split of the word
// into opcode and address (multiply, remainder, fix-up), operand read and
// execute; READ adds a second split of the input value and divide adds the
// 1-bit-per-cycle divider.
// The result is held in the output register until m_axis_tready; no new
// item is taken while it waits.
module decimal_accumulator_cpu #(
  parameter int unsigned MemoryWords = dac_pkg::MemoryWordsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [13:0] load_address, [45:14] load_word, [77:46] read_value, [79:78] zero
  input  logic [dac_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] action
  input  logic [dac_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] write_value, [63:32] accumulator, [77:64] program_counter,
  // [79:78] zero
  output logic [dac_pkg::OutDataW-1:0]  m_axis_tdata,
  // [2:0] status, [3] write_valid
  output logic [dac_pkg::OutUserW-1:0]  m_axis_tuser
);
  import dac_pkg::*;

  localparam int unsigned AW = $clog2(MemoryWords + 1);
  localparam logic [31:0] MW32 = 32'(MemoryWords);
  // floor(2^32 / MemoryWords): quotient estimate is exact or one low
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'(MemoryWords));

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LDCHK  = 4'd2;
  localparam logic [3:0] S_FETCH  = 4'd3;
  localparam logic [3:0] S_SPMUL  = 4'd4;
  localparam logic [3:0] S_SPREM  = 4'd5;
  localparam logic [3:0] S_SPFIX  = 4'd6;
  localparam logic [3:0] S_OPER   = 4'd7;
  localparam logic [3:0] S_DIVACC = 4'd8;

  // Main memory
  logic [31:0]   mem_q [MemoryWords];
  logic [31:0]   rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // Control and architectural state
  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [31:0]   word_q, word_d;
  logic [31:0]   rdval_q, rdval_d;
  logic [31:0]   acc_q, acc_d;
  logic [AW-1:0] pc_q, pc_d;
  logic [2:0]    stop_q, stop_d;
  logic signed [31:0] op_q, op_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          ov_q, ov_d;
  logic [2:0]    status_q, status_d;
  logic          wv_q, wv_d;
  logic [31:0]   wval_q, wval_d;

  // Split by MemoryWords: magnitude, quotient estimate, remainder, fix-up
  logic [31:0]   sp_abs_q, sp_abs_d;
  logic          sp_neg_q, sp_neg_d;
  logic          sp_rd_q, sp_rd_d;
  logic [31:0]   sp_qe_q, sp_qe_d;
  logic [31:0]   sp_rem_q, sp_rem_d;
  logic [63:0]   sp_prod;
  logic          sp_big;
  logic [31:0]   sp_q, sp_r, sp_quo, sp_remv;

  assign sp_prod = 64'(sp_abs_q) * 64'(Recip);
  assign sp_big  = (sp_rem_q >= MW32);
  assign sp_q    = sp_big ? (sp_qe_q + 32'd1) : sp_qe_q;
  assign sp_r    = sp_big ? (sp_rem_q - MW32) : sp_rem_q;
  assign sp_quo  = sp_neg_q ? (32'd0 - sp_q) : sp_q;
  assign sp_remv = sp_neg_q ? (32'd0 - sp_r) : sp_r;

  // Signed divider for the divide instruction
  logic          dv_start;
  logic [31:0]   dv_a, dv_b;
  logic [32:0]   div_rem_q, div_rem_d;
  logic [31:0]   div_quo_q, div_quo_d;
  logic [31:0]   div_dvs_q, div_dvs_d;
  logic [5:0]    div_cnt_q, div_cnt_d;
  logic          div_qneg_q, div_qneg_d;
  logic [32:0]   div_shift, div_trial;
  logic [31:0]   quo_res;

  assign div_shift = {div_rem_q[31:0], div_quo_q[31]};
  assign div_trial = div_shift - {1'b0, div_dvs_q};
  assign quo_res   = div_qneg_q ? (32'd0 - div_quo_q) : div_quo_q;

  always_comb begin
    div_rem_d  = div_rem_q;
    div_quo_d  = div_quo_q;
    div_dvs_d  = div_dvs_q;
    div_cnt_d  = div_cnt_q;
    div_qneg_d = div_qneg_q;
    if (dv_start) begin
      div_rem_d  = '0;
      div_quo_d  = dv_a[31] ? (32'd0 - dv_a) : dv_a;
      div_dvs_d  = dv_b[31] ? (32'd0 - dv_b) : dv_b;
      div_cnt_d  = 6'd32;
      div_qneg_d = dv_a[31] ^ dv_b[31];
    end else if (div_cnt_q != 6'd0) begin
      // restoring step, one quotient bit
      if (!div_trial[32]) begin
        div_rem_d = div_trial;
        div_quo_d = {div_quo_q[30:0], 1'b1};
      end else begin
        div_rem_d = div_shift;
        div_quo_d = {div_quo_q[30:0], 1'b0};
      end
      div_cnt_d = div_cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else begin
      div_cnt_q <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q  <= div_rem_d;
    div_quo_q  <= div_quo_d;
    div_dvs_q  <= div_dvs_d;
    div_qneg_q <= div_qneg_d;
  end

  // Input fields
  logic          in_fire;
  logic [31:0]   in_addr32;
  logic [AW-1:0] pc_inc;
  logic          fin;
  logic [2:0]    fin_status;
  logic          ex_adv, ex_jmp, ex_wv;
  logic [31:0]   ex_wval;
  logic [31:0]   m_op;

  assign s_axis_tready = (state_q == S_IDLE) && !ov_q;
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_addr32 = 32'(s_axis_tdata[AddrFieldW-1:0]);
  assign pc_inc    = pc_q + AW'(1);
  assign m_op      = rdata_q;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    addr_d   = addr_q;
    word_d   = word_q;
    rdval_d  = rdval_q;
    acc_d    = acc_q;
    pc_d     = pc_q;
    stop_d   = stop_q;
    op_d     = op_q;
    idx_d    = idx_q;
    ov_d     = ov_q;
    status_d = status_q;
    wv_d     = wv_q;
    wval_d   = wval_q;
    sp_abs_d = sp_abs_q;
    sp_neg_d = sp_neg_q;
    sp_rd_d  = sp_rd_q;
    sp_qe_d  = sp_qe_q;
    sp_rem_d = sp_rem_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    dv_start  = 1'b0;
    dv_a      = '0;
    dv_b      = '0;
    fin        = 1'b0;
    fin_status = ST_EXECUTED;
    ex_adv  = 1'b0;
    ex_jmp  = 1'b0;
    ex_wv   = 1'b0;
    ex_wval = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (32'(clr_q) == MW32 - 32'd1) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (ov_q && m_axis_tready) begin
          ov_d = 1'b0;
        end
        if (in_fire) begin
          addr_d  = in_addr32[AW-1:0];
          word_d  = s_axis_tdata[45:14];
          rdval_d = s_axis_tdata[77:46];
          if (s_axis_tuser[0] == ACT_LOAD) begin
            if (in_addr32 < MW32) begin
              mem_raddr = in_addr32[AW-1:0];
              state_d   = S_LDCHK;
            end else begin
              fin        = 1'b1;
              fin_status = ST_REJECTED;
            end
          end else if (stop_q != ST_RUNNING) begin
            fin        = 1'b1;
            fin_status = stop_q;
          end else if (32'(pc_q) >= MW32) begin
            stop_d     = ST_OFF_END;
            fin        = 1'b1;
            fin_status = ST_OFF_END;
          end else begin
            mem_raddr = pc_q;
            state_d   = S_FETCH;
          end
        end
      end
      S_LDCHK: begin
        fin = 1'b1;
        if (rdata_q == 32'd0) begin
          mem_we     = 1'b1;
          mem_waddr  = addr_q;
          mem_wdata  = word_q;
          fin_status = ST_LOADED;
        end else begin
          fin_status = ST_REJECTED;
        end
      end
      S_FETCH: begin
        // split the word into opcode and address
        sp_abs_d = rdata_q[31] ? (32'd0 - rdata_q) : rdata_q;
        sp_neg_d = rdata_q[31];
        sp_rd_d  = 1'b0;
        state_d  = S_SPMUL;
      end
      S_SPMUL: begin
        sp_qe_d = sp_prod[63:32];
        state_d = S_SPREM;
      end
      S_SPREM: begin
        sp_rem_d = sp_abs_q - sp_qe_q * MW32;
        state_d  = S_SPFIX;
      end
      S_SPFIX: begin
        if (sp_rd_q) begin
          // READ stores the signed remainder of the input value
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = sp_remv;
          ex_adv    = 1'b1;
        end else begin
          op_d      = sp_quo;
          idx_d     = sp_remv[31] ? '0 : sp_remv[AW-1:0];
          mem_raddr = sp_remv[31] ? '0 : sp_remv[AW-1:0];
          state_d   = S_OPER;
        end
      end
      S_OPER: begin
        unique case (op_q)
          OP_NOP:   ex_adv = 1'b1;
          OP_ADD: begin
            acc_d  = acc_q + m_op;
            ex_adv = 1'b1;
          end
          OP_SUB: begin
            acc_d  = acc_q - m_op;
            ex_adv = 1'b1;
          end
          OP_MUL: begin
            acc_d  = 32'(acc_q * m_op);
            ex_adv = 1'b1;
          end
          OP_DIV: begin
            if (m_op == 32'd0) begin
              stop_d     = ST_DIV_ZERO;
              fin        = 1'b1;
              fin_status = ST_DIV_ZERO;
            end else begin
              dv_start = 1'b1;
              dv_a     = acc_q;
              dv_b     = m_op;
              state_d  = S_DIVACC;
            end
          end
          OP_LOAD: begin
            acc_d  = m_op;
            ex_adv = 1'b1;
          end
          OP_STORE: begin
            mem_we    = 1'b1;
            mem_waddr = idx_q;
            mem_wdata = acc_q;
            ex_adv    = 1'b1;
          end
          OP_READ: begin
            sp_abs_d = rdval_q[31] ? (32'd0 - rdval_q) : rdval_q;
            sp_neg_d = rdval_q[31];
            sp_rd_d  = 1'b1;
            state_d  = S_SPMUL;
          end
          OP_WRITE: begin
            ex_wv   = 1'b1;
            ex_wval = m_op;
            ex_adv  = 1'b1;
          end
          OP_BR: begin
            ex_jmp = 1'b1;
            ex_adv = 1'b1;
          end
          OP_BRN: begin
            ex_jmp = acc_q[31];
            ex_adv = 1'b1;
          end
          OP_BRZ: begin
            ex_jmp = (acc_q == 32'd0);
            ex_adv = 1'b1;
          end
          OP_BRP: begin
            ex_jmp = !acc_q[31] && (acc_q != 32'd0);
            ex_adv = 1'b1;
          end
          OP_HALT: begin
            stop_d     = ST_HALTED;
            fin        = 1'b1;
            fin_status = ST_HALTED;
          end
          default: begin
            stop_d     = ST_ILLEGAL;
            fin        = 1'b1;
            fin_status = ST_ILLEGAL;
          end
        endcase
      end
      S_DIVACC: begin
        if (div_cnt_q == 6'd0) begin
          acc_d  = quo_res;
          ex_adv = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // counter update after an executed instruction
    if (ex_adv) begin
      fin = 1'b1;
      if (ex_jmp) begin
        pc_d       = idx_q;
        fin_status = ST_EXECUTED;
      end else begin
        pc_d = pc_inc;
        if (32'(pc_inc) >= MW32) begin
          stop_d     = ST_OFF_END;
          fin_status = ST_OFF_END;
        end else begin
          fin_status = ST_EXECUTED;
        end
      end
    end

    // result register
    if (fin) begin
      ov_d     = 1'b1;
      status_d = fin_status;
      wv_d     = ex_wv;
      wval_d   = ex_wval;
      state_d  = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      acc_q   <= '0;
      pc_q    <= '0;
      stop_q  <= ST_RUNNING;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      acc_q   <= acc_d;
      pc_q    <= pc_d;
      stop_q  <= stop_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    word_q   <= word_d;
    rdval_q  <= rdval_d;
    op_q     <= op_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    wv_q     <= wv_d;
    wval_q   <= wval_d;
    sp_abs_q <= sp_abs_d;
    sp_neg_q <= sp_neg_d;
    sp_rd_q  <= sp_rd_d;
    sp_qe_q  <= sp_qe_d;
    sp_rem_q <= sp_rem_d;
  end

  // Output item
  logic [31:0] pc_ext;
  assign pc_ext        = 32'(pc_q);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, pc_ext[AddrFieldW-1:0], acc_q, wval_q};
  assign m_axis_tuser  = {wv_q, status_q};

endmodule

### rtl/core/dac_checker.sv
module dac_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dac_pkg::OutUserW-1:0]  m_axis_tuser
);
  import dac_pkg::*;

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  // one item at a time: no intake while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");

  // write flag only on executed or off-end steps
  a_write_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3] |->
      (m_axis_tuser[2:0] == ST_EXECUTED) || (m_axis_tuser[2:0] == ST_OFF_END))
    else $error("write flag on non-executing result");

  // status code seven is never produced
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[2:0] != 3'd7)
    else $error("status out of range");

endmodule

bind decimal_accumulator_cpu dac_checker u_dac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser)
);

### verif/dac_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts each result and compares it with the block
module dac_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [13:0] load_address, [45:14] load_word, [77:46] read_value, [79:78] zero
  input  logic [79:0] s_axis_tdata,
  // [0] action
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] write_value, [63:32] accumulator, [77:64] program_counter, [79:78] zero
  input  logic [79:0] m_axis_tdata,
  // [2:0] status, [3] write_valid
  input  logic [3:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);
  import dac_pkg::*;

  localparam int Words = MemoryWordsDefault;

  typedef struct packed {
    logic [2:0]  status;
    logic        wr_valid;
    logic [31:0] wr_value;
    logic [31:0] acc;
    logic [13:0] pc;
  } outcome_t;

  // Shadow machine state
  logic [31:0] mem [Words];
  logic [31:0] acc_q;
  logic [13:0] pc_q;
  logic [2:0]  stop_q;
  outcome_t    outcome_q[$];

  initial begin
    for (int i = 0; i < Words; i++) mem[i] = '0;
    acc_q = '0;
    pc_q = '0;
    stop_q = ST_RUNNING;
    fail_count_o = 0;
    pending_o = 0;
  end

  // One item through the shadow machine
  function automatic outcome_t run_machine(logic act, logic [13:0] la, logic [31:0] lw,
                                           logic [31:0] rv);
    outcome_t r;
    longint w, op, loc, a, m;
    int idx;
    logic jump, stopped;
    r = '0;
    jump = 1'b0;
    stopped = 1'b0;
    if (act == ACT_LOAD) begin
      if (la < Words && mem[la] == 0) begin
        mem[la] = lw;
        r.status = ST_LOADED;
      end else begin
        r.status = ST_REJECTED;
      end
    end else if (stop_q != ST_RUNNING) begin
      r.status = stop_q;
    end else if (pc_q >= Words) begin
      stop_q = ST_OFF_END;
      r.status = ST_OFF_END;
    end else begin
      w = longint'($signed(mem[pc_q]));
      op = w / Words;
      loc = w % Words;
      idx = (loc >= 0) ? int'(loc) : 0;
      a = longint'($signed(acc_q));
      m = longint'($signed(mem[idx]));
      r.status = ST_EXECUTED;
      case (op)
        OP_NOP: ;
        OP_ADD: acc_q = 32'(a + m);
        OP_SUB: acc_q = 32'(a - m);
        OP_MUL: acc_q = 32'(a * m);
        OP_DIV: begin
          if (m == 0) begin
            stop_q = ST_DIV_ZERO;
            stopped = 1'b1;
          end else begin
            acc_q = 32'(a / m);
          end
        end
        OP_LOAD:  acc_q = mem[idx];
        OP_STORE: mem[idx] = acc_q;
        OP_READ:  mem[idx] = 32'(longint'($signed(rv)) % Words);
        OP_WRITE: begin
          r.wr_valid = 1'b1;
          r.wr_value = mem[idx];
        end
        OP_BR:  jump = 1'b1;
        OP_BRN: jump = (a < 0);
        OP_BRZ: jump = (a == 0);
        OP_BRP: jump = (a > 0);
        OP_HALT: begin
          stop_q = ST_HALTED;
          stopped = 1'b1;
        end
        default: begin
          stop_q = ST_ILLEGAL;
          stopped = 1'b1;
        end
      endcase
      if (stopped) begin
        r.status = stop_q;
      end else if (jump) begin
        pc_q = 14'(idx);
      end else begin
        pc_q = pc_q + 14'd1;
        if (pc_q >= Words) begin
          stop_q = ST_OFF_END;
          r.status = ST_OFF_END;
        end
      end
    end
    r.acc = acc_q;
    r.pc = pc_q;
    return r;
  endfunction

  always @(posedge clk_i) begin
    outcome_t got, want;
    if (rst_ni) begin
      // Accepted input item: predict
      if (s_axis_tvalid && s_axis_tready) begin
        outcome_q.push_back(run_machine(s_axis_tuser[0], s_axis_tdata[13:0],
                                        s_axis_tdata[45:14], s_axis_tdata[77:46]));
      end
      // Accepted result item: compare with oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser[2:0];
        got.wr_valid = m_axis_tuser[3];
        got.wr_value = m_axis_tdata[31:0];
        got.acc = m_axis_tdata[63:32];
        got.pc = m_axis_tdata[77:64];
        if (outcome_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result item: %p", got);
        end else begin
          want = outcome_q.pop_front();
          if (got != want || m_axis_tdata[79:78] != 2'b00) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("result mismatch: expected %p", want);
              $display("                 actual   %p", got);
            end
          end
        end
      end
      pending_o <= outcome_q.size();
    end
  end

endmodule

### verif/decimal_accumulator_cpu_tb.sv
`timescale 1ns / 1ps

module decimal_accumulator_cpu_tb;
  import dac_pkg::*;

  localparam int ProgLen = 900;
  localparam int CycleLimit = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  int          fail_count;
  int          pending;
  int          sent_cnt = 0;
  int          cycle_cnt = 0;
  logic        quiet = 1'b0;
  logic [31:0] program_q[$];

  always #1 clk_i = ~clk_i;

  decimal_accumulator_cpu uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  dac_scoreboard u_scoreboard (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [31:0] instr(logic signed [31:0] op, int addr);
    return 32'(op * MemoryWordsDefault + addr);
  endfunction

  // Offer one item and wait until it is taken; now and then a random gap ahead of it
  task automatic push_item(logic act, int addr, logic [31:0] word, logic [31:0] rv);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {2'b00, rv, word, 14'(addr)};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_cnt++;
  endtask

  task automatic load_cell(int addr, logic [31:0] word);
    push_item(ACT_LOAD, addr, word, $urandom());
  endtask

  // Operator input, extremes now and then
  function automatic logic [31:0] pick_input();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Random program body with forward branches only
  function automatic logic [31:0] random_instr(int at);
    int tgt;
    tgt = at + $urandom_range(1, 8);
    if (tgt > ProgLen - 1) tgt = ProgLen - 1;
    case ($urandom_range(0, 12))
      0:  return instr(OP_NOP, $urandom_range(0, 9999));
      1:  return instr(OP_ADD, $urandom_range(8000, 9997));
      2:  return instr(OP_SUB, $urandom_range(8000, 9997));
      3:  return instr(OP_MUL, $urandom_range(8000, 9997));
      4:  return instr(OP_DIV, $urandom_range(9000, 9997));
      5:  return instr(OP_LOAD, $urandom_range(8000, 9997));
      6:  return instr(OP_STORE, $urandom_range(8000, 8998));
      7:  return instr(OP_READ, $urandom_range(8000, 8998));
      8:  return instr(OP_WRITE, $urandom_range(8000, 9997));
      9:  return instr(OP_BR, tgt);
      10: return instr(OP_BRN, tgt);
      11: return instr(OP_BRZ, tgt);
      default: return instr(OP_BRP, tgt);
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [31:0] w;
    int n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed loads: out-of-range addresses, data extremes, overwrite refused
    load_cell(16383, 32'h1234_5678);
    load_cell(10000, 32'hffff_ffff);
    load_cell(9000, 32'hffff_ffff);
    load_cell(9001, 32'h8000_0000);
    load_cell(9002, 32'h7fff_ffff);
    load_cell(9003, 32'h0000_0001);
    load_cell(9000, 32'h0000_0005);

    // Data region with nonzero words
    for (int a = 9004; a < 9150; a++) begin
      w = $urandom();
      if (w == 0) w = 1;
      load_cell(a, w);
    end

    // Directed program head: divide overflow, wraps, negative no-op, reads, branches
    program_q = {
      instr(OP_LOAD, 9001), instr(OP_DIV, 9000), instr(OP_WRITE, 9001),
      instr(OP_MUL, 9002), instr(OP_ADD, 9002), instr(OP_SUB, 9001),
      32'hffff_fffb, 32'h0, instr(OP_READ, 8000), instr(OP_READ, 8001),
      instr(OP_WRITE, 8000), instr(OP_LOAD, 8000), instr(OP_BRN, 14),
      instr(OP_HALT, 0), instr(OP_LOAD, 9003), instr(OP_BRP, 16),
      instr(OP_BRZ, 0), instr(OP_BR, 19), instr(OP_HALT, 0), instr(OP_STORE, 8002)
    };
    while (program_q.size() < ProgLen - 1) program_q.push_back(random_instr(program_q.size()));
    // Final stop kind chosen at random
    case ($urandom_range(0, 4))
      0: program_q.push_back(instr(OP_HALT, 0));
      1: program_q.push_back(instr(32'sd14 + $urandom_range(0, 200000), $urandom_range(0, 9999)));
      2: program_q.push_back(32'(-longint'($urandom_range(10000, 32'h7fff_ffff))));
      3: program_q.push_back(instr(OP_DIV, 9998));
      default: program_q.push_back(instr(OP_BR, 9999));
    endcase

    // Program load with stray loads mixed in
    for (int i = 0; i < ProgLen; i++) begin
      load_cell(i, program_q[i]);
      if ($urandom_range(0, 15) == 0) begin
        n = ($urandom_range(0, 1) == 0) ? $urandom_range(ProgLen, 9997)
                                         : $urandom_range(10000, 16383);
        load_cell(n, $urandom());
      end
    end

    // Execute; steps beyond the stop repeat its status
    for (int i = 0; i < ProgLen + 60; i++) begin
      if (i > ProgLen - 200) quiet = 1'b1;
      push_item(ACT_STEP, $urandom_range(0, 16383), $urandom(), pick_input());
    end
    s_axis_tvalid <= 1'b0;

    // Drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("decimal_accumulator_cpu_tb: done, clean");
    end else begin
      $display("decimal_accumulator_cpu_tb: done, errors");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off to back up the input
  initial begin
    logic held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && sent_cnt > 400) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        held = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("decimal_accumulator_cpu_tb: done, errors");
      $finish;
    end
  end

endmodule
